### hw/rtl/vcte_pkg.sv
package vcte_pkg;

    // Widths of the fixed payload fields.
    localparam int XLEN   = 64;
    localparam int IX_W   = 6;
    localparam int NUM_IMPL = 56;

    // Privilege mode codes as they appear on the result.
    localparam logic [1:0] MODE_M = 2'd0;
    localparam logic [1:0] MODE_S = 2'd1;
    localparam logic [1:0] MODE_U = 2'd2;

    // Instruction encodings.
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [2:0] F3_CSRW   = 3'd1;
    localparam logic [2:0] F3_CSRR   = 3'd2;

    // CSR numbers with special meaning.
    localparam logic [11:0] CSR_VENDOR_ID_NUM = 12'hF11;
    localparam logic [11:0] CSR_SRET      = 12'h102;
    localparam logic [11:0] CSR_MRET      = 12'h302;
    localparam logic [11:0] LIMIT_U       = 12'h045;
    localparam logic [11:0] LIMIT_S       = 12'h181;

    // Trap causes that end the guest.
    localparam logic [5:0] CAUSE_LOAD_PF  = 6'd13;
    localparam logic [5:0] CAUSE_INST_PF  = 6'd12;
    localparam logic [5:0] CAUSE_STORE_PF = 6'd15;

    // Positions of entries in the CSR file.
    localparam logic [IX_W-1:0] IX_SSTATUS   = 6'd8;
    localparam logic [IX_W-1:0] IX_STVEC     = 6'd12;
    localparam logic [IX_W-1:0] IX_SEPC      = 6'd15;
    localparam logic [IX_W-1:0] IX_MVENDORID = 6'd20;
    localparam logic [IX_W-1:0] IX_MSTATUS   = 6'd24;
    localparam logic [IX_W-1:0] IX_MEPC      = 6'd33;
    localparam logic [IX_W-1:0] IX_PMPADDR0  = 6'd40;

    localparam logic [XLEN-1:0] MVENDORID_RST = 64'h0000_6373_6535_3336;
    localparam logic [XLEN-1:0] PMPADDR0_RST  = 64'h0000_0000_8040_0000;
    localparam int SPP_BIT   = 8;
    localparam int MPP_LSB   = 11;
    localparam logic [3:0] RD_NONE = 4'd15;

    // Architectural numbers of the implemented CSRs, in entry order.
    localparam logic [11:0] CSR_NUMS [NUM_IMPL] = '{
        12'h000, 12'h004, 12'h005, 12'h040, 12'h041, 12'h042, 12'h043, 12'h044,
        12'h100, 12'h102, 12'h103, 12'h104, 12'h105, 12'h106, 12'h140, 12'h141,
        12'h142, 12'h143, 12'h144, 12'h180, 12'hF11, 12'hF12, 12'hF13, 12'hF14,
        12'h300, 12'h301, 12'h302, 12'h303, 12'h304, 12'h305, 12'h306, 12'h310,
        12'h340, 12'h341, 12'h342, 12'h343, 12'h344, 12'h34A, 12'h34B, 12'h3A0,
        12'h3B0, 12'h3B1, 12'h3B2, 12'h3B3, 12'h3B4, 12'h3B5, 12'h3B6, 12'h3B7,
        12'h3B8, 12'h3B9, 12'h3BA, 12'h3BB, 12'h3BC, 12'h3BD, 12'h3BE, 12'h3BF
    };

    typedef struct packed {
        logic            func;
        logic [31:0]     instruction;
        logic [XLEN-1:0] pc;
        logic [5:0]      trap_cause;
        logic [XLEN-1:0] source_value;
    } t_in;

    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic            reg_write;
        logic [3:0]      reg_index;
        logic [XLEN-1:0] reg_value;
        logic            kill;
        logic [1:0]      priv_level;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic read;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic            hit;
        logic [IX_W-1:0] ix;
    } t_lookup;

    // Maps a CSR number to its entry; hit is low for unimplemented numbers.
    function automatic t_lookup csr_lookup(input logic [11:0] num);
        t_lookup res;
        res.hit = 1'b0;
        res.ix  = '0;
        for (int k = 0; k < NUM_IMPL; k++) begin
            if (CSR_NUMS[k] == num) begin
                res.hit = 1'b1;
                res.ix  = IX_W'(k);
            end
        end
        return res;
    endfunction

    // Value an entry holds before it is first written.
    function automatic logic [XLEN-1:0] csr_reset_val(input logic [IX_W-1:0] ix);
        logic [XLEN-1:0] val;
        val = '0;
        if (ix == IX_MVENDORID) begin
            val = MVENDORID_RST;
        end else if (ix == IX_PMPADDR0) begin
            val = PMPADDR0_RST;
        end
        return val;
    endfunction

endpackage

### hw/rtl/vcte_ctrl.sv
module vcte_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output vcte_pkg::t_cmd o_cmd
);
    import vcte_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // The output register can take a result when it is empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands to the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_EXEC;
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A result stays on offer until its transfer completes.
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/vcte_datapath.sv
module vcte_datapath #(
    parameter int CSR_ENTRIES = 56
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vcte_pkg::t_cmd i_cmd,
    input  vcte_pkg::t_in  i_in,
    output vcte_pkg::t_out o_out
);
    import vcte_pkg::*;

    localparam int IW = $clog2(CSR_ENTRIES);

    t_in               r_in;
    logic              r_hit;
    logic [IW-1:0]     r_ix;
    logic [XLEN-1:0]   r_rd;
    logic              r_rd_vld;
    logic [XLEN-1:0]   r_mem [CSR_ENTRIES];
    logic [CSR_ENTRIES-1:0] r_vld;
    logic [XLEN-1:0]   r_sstatus;
    logic [XLEN-1:0]   r_stvec;
    logic [XLEN-1:0]   r_sepc;
    logic [XLEN-1:0]   r_mstatus;
    logic [XLEN-1:0]   r_mepc;
    logic [1:0]        r_mode;
    t_out              r_out;

    logic [XLEN-1:0]   n_sstatus;
    logic [XLEN-1:0]   n_stvec;
    logic [XLEN-1:0]   n_sepc;
    logic [XLEN-1:0]   n_mstatus;
    logic [XLEN-1:0]   n_mepc;
    logic [1:0]        n_mode;
    t_out              n_out;
    logic              w_mem_we;
    t_lookup           w_lk;
    logic [IX_W-1:0]   w_ix;
    logic [XLEN-1:0]   w_entry;
    logic [6:0]        w_op;
    logic [4:0]        w_rd;
    logic [2:0]        w_f3;
    logic [11:0]       w_csr;
    logic [1:0]        w_mpp;
    logic              w_kill;
    logic              w_limit;

    // Instruction fields of the held item.
    assign w_op  = r_in.instruction[6:0];
    assign w_rd  = r_in.instruction[11:7];
    assign w_f3  = r_in.instruction[14:12];
    assign w_csr = r_in.instruction[31:20];
    assign w_lk  = csr_lookup(w_csr);
    assign w_ix  = IX_W'(r_ix);
    assign w_mpp = r_mstatus[MPP_LSB+1:MPP_LSB];

    // Input capture and CSR number decode.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
        if (i_cmd.decode) begin
            r_hit <= w_lk.hit;
            r_ix  <= w_lk.ix[IW-1:0];
        end
    end

    // CSR memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd     <= r_mem[r_ix];
            r_rd_vld <= r_vld[r_ix];
        end
        if (w_mem_we) begin
            r_mem[r_ix] <= r_in.source_value;
        end
    end

    // Written marks: an unwritten entry reads as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_mem_we) begin
            r_vld[r_ix] <= 1'b1;
        end
    end

    // Entries that the trap logic reads directly live in their own registers.
    always_comb begin
        unique case (w_ix)
            IX_SSTATUS: w_entry = r_sstatus;
            IX_STVEC:   w_entry = r_stvec;
            IX_SEPC:    w_entry = r_sepc;
            IX_MSTATUS: w_entry = r_mstatus;
            IX_MEPC:    w_entry = r_mepc;
            default: begin
                w_entry = r_rd_vld ? r_rd : csr_reset_val(w_ix);
            end
        endcase
    end

    // Mode limit on the CSR number; a read of mvendorid always passes.
    assign w_limit = !(w_csr == CSR_VENDOR_ID_NUM && w_f3 == F3_CSRR) &&
                     ((r_mode == MODE_U && w_csr > LIMIT_U) ||
                      (r_mode == MODE_S && w_csr > LIMIT_S));

    // Execution of the held item.
    always_comb begin
        n_sstatus = r_sstatus;
        n_stvec   = r_stvec;
        n_sepc    = r_sepc;
        n_mstatus = r_mstatus;
        n_mepc    = r_mepc;
        n_mode    = r_mode;
        w_mem_we  = 1'b0;
        w_kill    = 1'b0;
        n_out.next_pc   = r_in.pc;
        n_out.reg_write = 1'b0;
        n_out.reg_index = RD_NONE;
        n_out.reg_value = '0;
        if (r_in.func) begin
            n_sepc             = r_in.pc;
            n_out.next_pc      = r_stvec;
            n_mode             = MODE_S;
            n_sstatus[SPP_BIT] = 1'b1;
        end else if (r_in.trap_cause == CAUSE_INST_PF || r_in.trap_cause == CAUSE_LOAD_PF ||
                     r_in.trap_cause == CAUSE_STORE_PF) begin
            w_kill = 1'b1;
        end else if (w_limit) begin
            w_kill = 1'b1;
        end else if (w_op == OP_SYSTEM) begin
            if (w_f3 == F3_CSRW) begin
                if (!r_hit) begin
                    w_kill = 1'b1;
                end else begin
                    unique case (w_ix)
                        IX_SSTATUS: n_sstatus = r_in.source_value;
                        IX_STVEC:   n_stvec   = r_in.source_value;
                        IX_SEPC:    n_sepc    = r_in.source_value;
                        IX_MSTATUS: n_mstatus = r_in.source_value;
                        IX_MEPC:    n_mepc    = r_in.source_value;
                        default:    w_mem_we  = i_cmd.commit;
                    endcase
                    if (w_ix == IX_MVENDORID && r_in.source_value == '0) begin
                        w_kill = 1'b1;
                    end else begin
                        n_out.next_pc = r_in.pc + XLEN'(4);
                    end
                end
            end else if (w_f3 == F3_CSRR) begin
                if (!r_hit) begin
                    w_kill = 1'b1;
                end else begin
                    n_out.reg_write = 1'b1;
                    n_out.reg_index = (w_rd >= 5'd1 && w_rd <= 5'd15) ? w_rd[3:0] : RD_NONE;
                    n_out.reg_value = w_entry;
                    n_out.next_pc   = r_in.pc + XLEN'(4);
                end
            end else if (w_csr == CSR_SRET) begin
                if (r_sstatus[SPP_BIT]) begin
                    w_kill = 1'b1;
                end else begin
                    n_mode        = MODE_U;
                    n_out.next_pc = r_sepc;
                end
            end else if (w_csr == CSR_MRET) begin
                if (w_mpp == 2'd3) begin
                    w_kill = 1'b1;
                end else begin
                    if (w_mpp == 2'd1) begin
                        n_mode = MODE_S;
                    end else if (w_mpp == 2'd0) begin
                        n_mode = MODE_U;
                    end
                    n_out.next_pc = r_mepc;
                end
            end
        end
        // A killed item leaves the register file untouched and resumes nowhere new.
        if (w_kill) begin
            n_out.next_pc   = r_in.pc;
            n_out.reg_write = 1'b0;
            n_out.reg_index = RD_NONE;
            n_out.reg_value = '0;
        end
        n_out.kill       = w_kill;
        n_out.priv_level = n_mode;
    end

    // Architectural state update when the result is committed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sstatus <= '0;
            r_stvec   <= '0;
            r_sepc    <= '0;
            r_mstatus <= '0;
            r_mepc    <= '0;
            r_mode    <= MODE_M;
        end else if (i_cmd.commit) begin
            r_sstatus <= n_sstatus;
            r_stvec   <= n_stvec;
            r_sepc    <= n_sepc;
            r_mstatus <= n_mstatus;
            r_mepc    <= n_mepc;
            r_mode    <= n_mode;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

### hw/rtl/virtual_csr_trap_emulator_unit.sv
// Virtual CSR trap emulator.
// Input channel: i_in_valid / o_in_stall carry one trapped event (an ecall
// redirect or a privileged instruction) as a t_in word; a transfer happens
// at a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one t_out result per event:
// the resume pc, an optional general-register write, the kill flag and the
// guest privilege mode after the event.
// Sequence: after its input transfer an event passes through the decode of
// the CSR number, the registered read of the CSR memory and the execute step,
// whose commit registers the result. One event is in flight at a time, so the
// block takes no new event until the current one has been committed.
// Once a result is computed the block accepts the next event while that
// result still waits; a stalled receiver holds the result unchanged and the
// following event waits in the execute stage until the output register frees.
// Reset clears the privilege mode to machine, the trap CSRs to zero and the
// written marks of all CSR entries at once; unwritten entries read as their
// reset values, so no clearing pass is needed and input is taken at once.
module virtual_csr_trap_emulator_unit #(
    parameter int CSR_ENTRIES = 56
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  vcte_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output vcte_pkg::t_out o_out_data
);
    import vcte_pkg::*;

    t_cmd w_cmd;

    // Sequencer.
    vcte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // CSR file and trap logic.
    vcte_datapath #(
        .CSR_ENTRIES (CSR_ENTRIES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_in    (i_in_data),
        .o_out   (o_out_data)
    );

endmodule

### hw/rtl/vcte_checker.sv
module vcte_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input vcte_pkg::t_out o_out_data
);
    import vcte_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // A stalled result is held.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Only one event is taken at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second event taken while one is in flight");

    // A killed event writes no register: no write, no index and no value.
    a_kill_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kill |->
            !o_out_data.reg_write && o_out_data.reg_index == RD_NONE &&
            o_out_data.reg_value == '0)
        else $error("killed event carries a register write");

    // The privilege mode never takes the reserved code.
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.priv_level != 2'd3)
        else $error("reserved privilege mode reported");

endmodule

bind virtual_csr_trap_emulator_unit vcte_checker u_vcte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
